@@ sv/divisor_filter_compactor_top_assert.svh @@
// assertion macros for the divisor filter compactor
`ifndef DIVISOR_FILTER_COMPACTOR_TOP_ASSERT_SVH
`define DIVISOR_FILTER_COMPACTOR_TOP_ASSERT_SVH
`ifndef SYNTHESIS
`define DFC_ASSERT_IMPL(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define DFC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) ante |=> cons) else $error(msg);
`else
`define DFC_ASSERT_IMPL(lbl, clk, rst_n, prop, msg)
`define DFC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

@@ sv/dfc_pkg.sv @@
// shared types and constants of the divisor filter compactor
package dfc_pkg;
  localparam int MaxDivisors = 128;
  localparam int IdxW = $clog2(MaxDivisors);
  localparam int CntW = $clog2(MaxDivisors + 1);
  localparam int QDepth = 2;

  localparam logic [1:0] KIND_CLEAR = 2'd0;
  localparam logic [1:0] KIND_ADD   = 2'd1;
  localparam logic [1:0] KIND_DATA  = 2'd2;

  localparam logic RES_VALUE   = 1'b0;
  localparam logic RES_SUMMARY = 1'b1;

  // classified command from front to back
  typedef enum logic [1:0] {
    CMD_CLEAR = 2'd0,
    CMD_ADD   = 2'd1,
    CMD_DATA  = 2'd2
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t   kind;
    logic [31:0] value;
    logic [30:0] divisor;
    logic        batch_end;
  } cmd_t;

  typedef struct packed {
    logic        result_kind;
    logic [31:0] kept_value;
    logic [31:0] kept_count;
    logic [31:0] kept_sum;
    logic        final_of_run;
  } res_t;
endpackage

@@ sv/dfc_if.sv @@
// handshake channels of the divisor filter compactor
interface dfc_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [31:0] value;
  logic [30:0] divisor;
  logic        batch_end;
  modport source (output valid, kind, value, divisor, batch_end, input ready);
  modport sink (input valid, kind, value, divisor, batch_end, output ready);
endinterface

interface dfc_out_if;
  logic        valid;
  logic        ready;
  logic        result_kind;
  logic [31:0] kept_value;
  logic [31:0] kept_count;
  logic [31:0] kept_sum;
  logic        final_of_run;
  modport source (output valid, result_kind, kept_value, kept_count, kept_sum,
                  final_of_run, input ready);
  modport sink (input valid, result_kind, kept_value, kept_count, kept_sum,
                final_of_run, output ready);
endinterface

@@ sv/dfc_front.sv @@
// front: classifies input transactions and queues the useful ones
module dfc_front (
  input  logic          clk,
  input  logic          rst_n,
  dfc_in_if.sink        in_ch,
  output logic          q_valid,
  output dfc_pkg::cmd_t q_cmd,
  input  logic          q_pop
);
  localparam int PtrW = $clog2(dfc_pkg::QDepth);

  dfc_pkg::cmd_t    mem_r [dfc_pkg::QDepth];
  logic [PtrW-1:0]  wp_r, rp_r;
  logic [PtrW:0]    fill_r;
  logic             push, drop;
  dfc_pkg::cmd_t    cmd;

  assign in_ch.ready = (fill_r != PtrW'(0) + (PtrW+1)'(dfc_pkg::QDepth));
  // kind 3 and zero divisors never reach the back
  assign drop = (in_ch.kind != dfc_pkg::KIND_CLEAR) && (in_ch.kind != dfc_pkg::KIND_ADD)
             && (in_ch.kind != dfc_pkg::KIND_DATA)
             || ((in_ch.kind == dfc_pkg::KIND_ADD) && (in_ch.divisor == 31'd0));
  assign push = in_ch.valid && in_ch.ready && !drop;

  always_comb begin
    cmd.kind = dfc_pkg::CMD_DATA;
    case (in_ch.kind)
      dfc_pkg::KIND_CLEAR: cmd.kind = dfc_pkg::CMD_CLEAR;
      dfc_pkg::KIND_ADD:   cmd.kind = dfc_pkg::CMD_ADD;
      default:             cmd.kind = dfc_pkg::CMD_DATA;
    endcase
    cmd.value = in_ch.value;
    cmd.divisor = in_ch.divisor;
    cmd.batch_end = in_ch.batch_end;
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= cmd;
    end
    if (!rst_n) begin
      wp_r <= '0;
      rp_r <= '0;
      fill_r <= '0;
    end else begin
      if (push) wp_r <= wp_r + PtrW'(1);
      if (q_pop) rp_r <= rp_r + PtrW'(1);
      fill_r <= fill_r + (PtrW+1)'(push) - (PtrW+1)'(q_pop);
    end
  end

  assign q_valid = (fill_r != '0);
  assign q_cmd = mem_r[rp_r];
endmodule

@@ sv/dfc_divider.sv @@
// iterative 32-bit unsigned remainder, one bit per cycle
module dfc_divider (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [31:0] dividend,
  input  logic [30:0] divisor,
  output logic        done,
  output logic        is_zero
);
  logic [31:0] quo_r;
  logic [31:0] rem_r;
  logic [30:0] div_r;
  logic [5:0]  cnt_r;
  logic        busy_r;
  logic [32:0] shifted, diff;

  assign shifted = {rem_r, quo_r[31]};
  assign diff = shifted - {2'b0, div_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r <= 6'd32;
        quo_r <= dividend;
        rem_r <= '0;
        div_r <= divisor;
      end else if (busy_r) begin
        quo_r <= {quo_r[30:0], 1'b0};
        if (!diff[32]) rem_r <= diff[31:0];
        else rem_r <= shifted[31:0];
        cnt_r <= cnt_r - 6'd1;
        if (cnt_r == 6'd1) begin
          busy_r <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign is_zero = (rem_r == 32'd0);
endmodule

@@ sv/dfc_back.sv @@
// back: divisor table, divisibility sweep and result register
module dfc_back (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          q_valid,
  input  dfc_pkg::cmd_t q_cmd,
  output logic          q_pop,
  dfc_out_if.source     out_ch
);
  typedef enum logic [2:0] {
    ST_IDLE, ST_READ, ST_START, ST_WAIT, ST_EMIT_V, ST_EMIT_S
  } state_t;

  state_t                   state_r;
  logic [30:0]              table_r [dfc_pkg::MaxDivisors];
  logic [dfc_pkg::CntW-1:0] dcount_r;
  logic [dfc_pkg::CntW-1:0] idx_r;
  logic [30:0]              rd_r;
  logic [31:0]              mag_r;
  logic [31:0]              value_r;
  logic                     last_r;
  logic [31:0]              rcount_r, rsum_r;
  logic                     dv_start, dv_done, dv_zero;
  logic                     ovalid_r;
  logic                     emit_go;
  dfc_pkg::res_t            res_r;

  dfc_divider u_div (
    .clk(clk), .rst_n(rst_n), .start(dv_start), .dividend(mag_r), .divisor(rd_r),
    .done(dv_done), .is_zero(dv_zero)
  );

  assign dv_start = (state_r == ST_START);
  assign q_pop = (state_r == ST_IDLE) && q_valid;
  // result register free or draining this cycle
  assign emit_go = ((state_r == ST_EMIT_V) || (state_r == ST_EMIT_S))
                && (!ovalid_r || out_ch.ready);

  always_ff @(posedge clk) begin
    rd_r <= table_r[idx_r[dfc_pkg::IdxW-1:0]];
    if (q_pop && q_cmd.kind == dfc_pkg::CMD_ADD
        && dcount_r < dfc_pkg::CntW'(dfc_pkg::MaxDivisors)) begin
      table_r[dcount_r[dfc_pkg::IdxW-1:0]] <= q_cmd.divisor;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      dcount_r <= '0;
      idx_r <= '0;
      rcount_r <= '0;
      rsum_r <= '0;
      ovalid_r <= 1'b0;
    end else begin
      if (emit_go) ovalid_r <= 1'b1;
      else if (out_ch.ready) ovalid_r <= 1'b0;
      case (state_r)
        ST_IDLE: begin
          if (q_valid) begin
            case (q_cmd.kind)
              dfc_pkg::CMD_CLEAR: dcount_r <= '0;
              dfc_pkg::CMD_ADD: begin
                if (dcount_r < dfc_pkg::CntW'(dfc_pkg::MaxDivisors))
                  dcount_r <= dcount_r + dfc_pkg::CntW'(1);
              end
              default: begin
                value_r <= q_cmd.value;
                last_r <= q_cmd.batch_end;
                mag_r <= q_cmd.value[31] ? (32'd0 - q_cmd.value) : q_cmd.value;
                idx_r <= '0;
                state_r <= (dcount_r == '0) ? ST_EMIT_V : ST_READ;
              end
            endcase
          end
        end
        ST_READ: state_r <= ST_START;
        ST_START: state_r <= ST_WAIT;
        ST_WAIT: begin
          if (dv_done) begin
            if (dv_zero) begin
              state_r <= last_r ? ST_EMIT_S : ST_IDLE;
            end else if (idx_r + dfc_pkg::CntW'(1) == dcount_r) begin
              state_r <= ST_EMIT_V;
            end else begin
              idx_r <= idx_r + dfc_pkg::CntW'(1);
              state_r <= ST_READ;
            end
          end
        end
        ST_EMIT_V: begin
          if (emit_go) begin
            res_r <= '{dfc_pkg::RES_VALUE, value_r, 32'd0, 32'd0, !last_r};
            if (rcount_r != 32'hFFFF_FFFF) rcount_r <= rcount_r + 32'd1;
            rsum_r <= rsum_r + value_r;
            state_r <= last_r ? ST_EMIT_S : ST_IDLE;
          end
        end
        ST_EMIT_S: begin
          if (emit_go) begin
            res_r <= '{dfc_pkg::RES_SUMMARY, 32'd0, rcount_r, rsum_r, 1'b1};
            rcount_r <= '0;
            rsum_r <= '0;
            state_r <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign out_ch.valid = ovalid_r;
  assign out_ch.result_kind = res_r.result_kind;
  assign out_ch.kept_value = res_r.kept_value;
  assign out_ch.kept_count = res_r.kept_count;
  assign out_ch.kept_sum = res_r.kept_sum;
  assign out_ch.final_of_run = res_r.final_of_run;
endmodule

@@ sv/divisor_filter_compactor_top.sv @@
// top level of the divisor filter compactor
//   channel | dir | payload
//   in_     | in  | kind, value, divisor, batch_end
//   out_    | out | result_kind, kept_value, kept_count, kept_sum, final_of_run
// table loads and clears are applied by the back end in its idle state, as it pops them
// a data value runs, per stored divisor, a table read, a divider start, 32 remainder
// steps in the bit-serial remainder unit and a done check; it stops at the first divisor
// that divides it, up to 128 divisors, and each result then waits in an emit state for the output
// synchronous active-low reset clears counters, queue and table count; no clearing pass
// a two-entry queue lets the front accept while the back works or the output stalls
`include "divisor_filter_compactor_top_assert.svh"
module divisor_filter_compactor_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_kind,
  input  logic signed [31:0] in_value,
  input  logic [30:0] in_divisor,
  input  logic        in_batch_end,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_result_kind,
  output logic signed [31:0] out_kept_value,
  output logic [31:0] out_kept_count,
  output logic signed [31:0] out_kept_sum,
  output logic        out_final_of_run
);
  dfc_in_if  in_ch ();
  dfc_out_if out_ch ();
  logic          q_valid, q_pop;
  dfc_pkg::cmd_t q_cmd;

  // channel wiring
  assign in_ch.valid = in_valid;
  assign in_ch.kind = in_kind;
  assign in_ch.value = in_value;
  assign in_ch.divisor = in_divisor;
  assign in_ch.batch_end = in_batch_end;
  assign in_ready = in_ch.ready;
  assign out_valid = out_ch.valid;
  assign out_ch.ready = out_ready;
  assign out_result_kind = out_ch.result_kind;
  assign out_kept_value = out_ch.kept_value;
  assign out_kept_count = out_ch.kept_count;
  assign out_kept_sum = out_ch.kept_sum;
  assign out_final_of_run = out_ch.final_of_run;

  // front classifies each transaction and queues the useful ones
  dfc_front u_front (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch),
    .q_valid(q_valid), .q_cmd(q_cmd), .q_pop(q_pop)
  );

  // back runs the divisor sweep and emits results
  dfc_back u_back (
    .clk(clk), .rst_n(rst_n), .q_valid(q_valid), .q_cmd(q_cmd),
    .q_pop(q_pop), .out_ch(out_ch)
  );

  `DFC_ASSERT_IMPL(a_pop_valid, clk, rst_n, q_pop |-> q_valid, "pop from empty queue")
  `DFC_ASSERT_IMPL(a_summary_final, clk, rst_n,
    (out_valid && out_result_kind) |-> out_final_of_run, "summary not final")
  `DFC_ASSERT_NEXT(a_out_hold, clk, rst_n, (out_valid && !out_ready), out_valid,
    "result dropped under stall")
endmodule

@@ tb/tb_if.sv @@
// valid/ready channel interfaces used by the testbench
interface tb_in_if (input logic clk);
  timeunit 1ns;
  timeprecision 1ps;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [31:0] value;
  logic [30:0] divisor;
  logic        batch_end;
  modport source (output valid, kind, value, divisor, batch_end, input ready);
  modport sink (input valid, kind, value, divisor, batch_end, output ready);
endinterface

interface tb_out_if (input logic clk);
  timeunit 1ns;
  timeprecision 1ps;
  logic        valid;
  logic        ready;
  logic        result_kind;
  logic [31:0] kept_value;
  logic [31:0] kept_count;
  logic [31:0] kept_sum;
  logic        final_of_run;
  modport source (output valid, result_kind, kept_value, kept_count, kept_sum,
                  final_of_run, input ready);
  modport sink (input valid, result_kind, kept_value, kept_count, kept_sum,
                final_of_run, output ready);
endinterface

@@ tb/tb.sv @@
// testbench of the divisor filter compactor: directed and random streams
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WatchdogLimit = 40000;
  localparam int FlushCycles   = 200;
  localparam logic [1:0] KIND_UNUSED = 2'd3;

  logic clk;
  logic rst_n;

  tb_in_if  in_ch (clk);
  tb_out_if out_ch (clk);

  divisor_filter_compactor_top i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_ch.valid),
    .in_ready         (in_ch.ready),
    .in_kind          (in_ch.kind),
    .in_value         (in_ch.value),
    .in_divisor       (in_ch.divisor),
    .in_batch_end     (in_ch.batch_end),
    .out_valid        (out_ch.valid),
    .out_ready        (out_ch.ready),
    .out_result_kind  (out_ch.result_kind),
    .out_kept_value   (out_ch.kept_value),
    .out_kept_count   (out_ch.kept_count),
    .out_kept_sum     (out_ch.kept_sum),
    .out_final_of_run (out_ch.final_of_run)
  );

  // predictor state, mirrors the block
  logic [30:0]   div_table [dfc_pkg::MaxDivisors];
  int unsigned   div_count;
  logic [31:0]   batch_count;
  logic [31:0]   batch_sum;
  dfc_pkg::res_t expected_results [$];

  int mismatches;
  int idle_cycles;
  bit timed_out;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // magnitude test against every loaded divisor, stops at the first hit
  function automatic bit divisible_by_table(logic [31:0] bits);
    logic [31:0] mag;
    mag = bits[31] ? (32'd0 - bits) : bits;
    for (int i = 0; i < div_count; i++) begin
      if (div_table[i] != 0 && (mag % {1'b0, div_table[i]}) == 0) return 1'b1;
    end
    return 1'b0;
  endfunction

  // advance the predictor by one accepted transaction
  function automatic void predict_filter(logic [1:0] kind, logic [31:0] value,
                                         logic [30:0] divisor, logic last);
    dfc_pkg::res_t r;
    if (kind == dfc_pkg::KIND_CLEAR) begin
      div_count = 0;
    end else if (kind == dfc_pkg::KIND_ADD) begin
      if (divisor != 0 && div_count < dfc_pkg::MaxDivisors) begin
        div_table[div_count] = divisor;
        div_count++;
      end
    end else if (kind == dfc_pkg::KIND_DATA) begin
      if (!divisible_by_table(value)) begin
        if (batch_count != 32'hFFFF_FFFF) batch_count++;
        batch_sum = batch_sum + value;
        r = '0;
        r.result_kind  = dfc_pkg::RES_VALUE;
        r.kept_value   = value;
        r.final_of_run = !last;
        expected_results.push_back(r);
      end
      if (last) begin
        r = '0;
        r.result_kind  = dfc_pkg::RES_SUMMARY;
        r.kept_count   = batch_count;
        r.kept_sum     = batch_sum;
        r.final_of_run = 1'b1;
        expected_results.push_back(r);
        batch_count = 0;
        batch_sum   = 0;
      end
    end
  endfunction

  // send one transaction after a random gap, hold until accepted
  task automatic send_item(logic [1:0] kind, logic [31:0] value,
                           logic [30:0] divisor, logic last);
    int gap;
    gap = $urandom_range(0, 14);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.kind      <= kind;
    in_ch.value     <= value;
    in_ch.divisor   <= divisor;
    in_ch.batch_end <= last;
    do @(posedge clk); while (!in_ch.ready);
    predict_filter(kind, value, divisor, last);
  endtask

  task automatic send_data(logic [31:0] value, logic last);
    send_item(dfc_pkg::KIND_DATA, value, 31'($urandom), last);
  endtask

  task automatic send_divisor(logic [30:0] d);
    send_item(dfc_pkg::KIND_ADD, $urandom, d, 1'($urandom_range(0, 1)));
  endtask

  task automatic wait_drained();
    while (expected_results.size() != 0) @(posedge clk);
  endtask

  // sink side: random stalls, compare against oldest expectation
  initial begin
    dfc_pkg::res_t e;
    int stall;
    out_ch.ready = 1'b0;
    @(posedge clk iff rst_n);
    forever begin
      stall = $urandom_range(0, 14);
      if ($urandom_range(0, 3) == 0) stall = 0;
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!out_ch.valid);
      if (expected_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: kind %0d value %0d count %0d sum %0d final %0d",
                   out_ch.result_kind, $signed(out_ch.kept_value), out_ch.kept_count,
                   $signed(out_ch.kept_sum), out_ch.final_of_run);
      end else begin
        e = expected_results.pop_front();
        if (out_ch.result_kind !== e.result_kind || out_ch.kept_value !== e.kept_value ||
            out_ch.kept_count !== e.kept_count || out_ch.kept_sum !== e.kept_sum ||
            out_ch.final_of_run !== e.final_of_run) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp kind %0d value %0d count %0d sum %0d final %0d / act %0d %0d %0d %0d %0d",
                     e.result_kind, $signed(e.kept_value), e.kept_count,
                     $signed(e.kept_sum), e.final_of_run, out_ch.result_kind,
                     $signed(out_ch.kept_value), out_ch.kept_count,
                     $signed(out_ch.kept_sum), out_ch.final_of_run);
        end
      end
    end
  end

  // watchdog: cycles with no transaction on either channel
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WatchdogLimit && !timed_out) begin
      timed_out = 1'b1;
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // empty table passes everything, extremes of value, unused kind ignored
  task automatic test_empty_table();
    send_data(32'h0000_0000, 1'b0);
    send_data(32'h7FFF_FFFF, 1'b0);
    send_data(32'h8000_0000, 1'b0);
    send_data(32'hFFFF_FFFF, 1'b0);
    send_item(KIND_UNUSED, 32'h1234_5678, 31'h7FFF_FFFF, 1'b1);
    send_data(32'h0000_0001, 1'b1);
    send_data(32'h0000_0005, 1'b1);
  endtask

  // zero divisor dropped, negatives by magnitude, most negative value
  task automatic test_divisors();
    send_item(dfc_pkg::KIND_CLEAR, 32'hFFFF_FFFF, 31'h7FFF_FFFF, 1'b1);
    send_divisor(31'd0);
    send_data(32'd7, 1'b0);
    send_divisor(31'd3);
    send_divisor(31'h7FFF_FFFF);
    send_data(32'hFFFF_FFFD, 1'b0);
    send_data(32'hFFFF_FFFE, 1'b0);
    send_data(32'h7FFF_FFFF, 1'b0);
    send_data(32'h8000_0001, 1'b0);
    send_data(32'h8000_0000, 1'b1);
    send_divisor(31'd1);
    send_data(32'h8000_0000, 1'b1);
    send_item(dfc_pkg::KIND_CLEAR, 32'd0, 31'd0, 1'b0);
    send_divisor(31'h4000_0000);
    send_data(32'h8000_0000, 1'b0);
    send_data(32'h4000_0001, 1'b1);
  endtask

  // fill the table past its size, the extra loads are dropped
  task automatic test_full_table();
    send_item(dfc_pkg::KIND_CLEAR, 32'd0, 31'd0, 1'b0);
    for (int i = 0; i < dfc_pkg::MaxDivisors + 2; i++)
      send_divisor(31'(1000 + 2 * i));
    send_data(32'd2001, 1'b0);
    send_data(32'd1258, 1'b0);
    send_data(32'd1260, 1'b1);
  endtask

  // random batches over small tables, with noise items mixed in
  task automatic test_random_stream(int n_items);
    logic [31:0] v;
    int pick;
    for (int i = 0; i < n_items; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < 4) send_item(dfc_pkg::KIND_CLEAR, $urandom, 31'($urandom),
                              1'($urandom_range(0, 1)));
      else if (pick < 16) begin
        if (div_count > 6) send_item(dfc_pkg::KIND_CLEAR, $urandom, 31'($urandom), 1'b0);
        else send_divisor($urandom_range(0, 3) == 0 ? 31'($urandom) : 31'($urandom_range(0, 12)));
      end else if (pick < 19) send_item(KIND_UNUSED, $urandom, 31'($urandom),
                                        1'($urandom_range(0, 1)));
      else begin
        case ($urandom_range(0, 3))
          0: v = $urandom;
          1: v = $urandom_range(0, 200);
          2: v = -$urandom_range(0, 200);
          default: v = {$urandom_range(0, 1) ? 2'b10 : 2'b01, 30'($urandom)};
        endcase
        send_data(v, $urandom_range(0, 5) == 0);
      end
    end
    send_data($urandom, 1'b1);
  endtask

  initial begin
    int flush;
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.kind = dfc_pkg::KIND_CLEAR;
    in_ch.value = '0;
    in_ch.divisor = '0;
    in_ch.batch_end = 1'b0;
    div_count = 0;
    batch_count = 0;
    batch_sum = 0;
    mismatches = 0;
    idle_cycles = 0;
    timed_out = 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_empty_table();
    test_divisors();
    test_full_table();
    test_random_stream(12);
    in_ch.valid <= 1'b0;
    wait_drained();
    flush = 0;
    while (flush < FlushCycles && !out_ch.valid) begin
      @(posedge clk);
      flush++;
    end
    repeat (20) @(posedge clk);
    if (mismatches == 0 && expected_results.size() == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end
endmodule
